>>> rtl/core/apc_pkg.sv
// shared constants, types and datapath commands of the articulation point counter
package apc_pkg;

  localparam int VERT_W    = 10;
  localparam int VERTS     = 1 << VERT_W;
  localparam int SLOT_AW   = 13;
  localparam int SLOT_CAP  = 1 << SLOT_AW;
  localparam int LINK_W    = SLOT_AW + 1;
  localparam int SP_W      = VERT_W + 1;
  localparam int STACK_W   = VERT_W + LINK_W;
  localparam int PADDR_W   = 3;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_ROOT_VERTEX  = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_EDGE_A,
    OP_EDGE_B,
    OP_ROOT,
    OP_HEAD,
    OP_SLOT_RD,
    OP_NB,
    OP_DEC,
    OP_POP_RD,
    OP_POP,
    OP_FIN,
    OP_SWEEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic link_zero;
    logic sp_one;
    logic last_edge;
    logic sweep_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/core/apc_ifs.sv
// edge input and result output channel interfaces
interface apc_edge_if;
  logic                     valid;
  logic                     ready;
  logic [apc_pkg::VERT_W-1:0] edge_from;
  logic [apc_pkg::VERT_W-1:0] edge_to;
  logic                     last_edge;

  modport source (output valid, edge_from, edge_to, last_edge, input ready);
  modport sink (input valid, edge_from, edge_to, last_edge, output ready);
endinterface

interface apc_result_if;
  logic                     valid;
  logic                     ready;
  logic [apc_pkg::VERT_W-1:0] cut_vertex_count;
  logic                     edges_dropped;

  modport source (output valid, cut_vertex_count, edges_dropped, input ready);
  modport sink (input valid, cut_vertex_count, edges_dropped, output ready);
endinterface

>>> rtl/core/articulation_point_counter_top.sv
// articulation point counter top level with configuration registers
//
//  channel     dir   transfer payload
//  edge_in     in    edge_from, edge_to, last_edge
//  result_out  out   cut_vertex_count, edges_dropped
//  apb         in    vertex_count at 0x0, root_vertex at 0x4
//
// each edge is accepted, then linked into the two adjacency lists in the EDGE_A and EDGE_B steps
// after the last edge the walk runs test, neighbour and decide per adjacency slot,
// test and pop per return to a parent, root and head to start, test and fin to end,
// then a mark sweep of all 1024 vertex addresses, which also clears the list heads
// and visited bits for the next graph, then tail state, then result register load
// after reset the same sweep and tail run before the first edge is taken
// a waiting result holds the next graph at its hand-off, and its edges wait with it
module articulation_point_counter_top import apc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  apc_edge_if.sink           edge_in,
  apc_result_if.source       result_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [VERT_W-1:0] vertex_count;
  logic [VERT_W-1:0] root_vertex;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERT_W'(1);
      root_vertex  <= VERT_W'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_VERTEX_COUNT: vertex_count <= pwdata[VERT_W-1:0];
        REG_ROOT_VERTEX:  root_vertex  <= pwdata[VERT_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_ROOT_VERTEX) ? {22'd0, root_vertex}
                                                : {22'd0, vertex_count};

  apc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edge_in.valid),
    .in_ready (edge_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .vertex_count     (vertex_count),
    .root_vertex      (root_vertex),
    .edge_from        (edge_in.edge_from),
    .edge_to          (edge_in.edge_to),
    .last_edge        (edge_in.last_edge),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .cut_vertex_count (result_out.cut_vertex_count),
    .edges_dropped    (result_out.edges_dropped)
  );

endmodule

>>> rtl/core/apc_datapath.sv
// adjacency store, per-vertex memories, walk stack and result register
module apc_datapath import apc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [VERT_W-1:0] vertex_count,
  input  logic [VERT_W-1:0] root_vertex,
  input  logic [VERT_W-1:0] edge_from,
  input  logic [VERT_W-1:0] edge_to,
  input  logic              last_edge,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VERT_W-1:0] cut_vertex_count,
  output logic              edges_dropped
);

  // memories
  logic [LINK_W-1:0]  head_mem   [VERTS];
  logic [STACK_W-1:0] slot_mem   [SLOT_CAP];
  logic               vis_mem    [VERTS];
  logic [VERT_W-1:0]  disc_mem   [VERTS];
  logic [VERT_W-1:0]  low_mem    [VERTS];
  logic [VERT_W-1:0]  parent_mem [VERTS];
  logic [STACK_W-1:0] stack_mem  [VERTS];
  logic               cut_mem    [VERTS];

  logic [LINK_W-1:0]  head_rd;
  logic [STACK_W-1:0] slot_rd;
  logic               vis_rd;
  logic [VERT_W-1:0]  disc_rd;
  logic [VERT_W-1:0]  low_rd;
  logic [VERT_W-1:0]  parent_rd;
  logic [STACK_W-1:0] stack_rd;
  logic               cut_rd;

  // registers
  logic [VERT_W-1:0]  ea;
  logic [VERT_W-1:0]  eb;
  logic               elast;
  logic               skip;
  logic [LINK_W-1:0]  su;
  logic               drop;
  logic [VERT_W-1:0]  r_v;
  logic [VERT_W-1:0]  cur_u;
  logic [VERT_W-1:0]  cur_parent;
  logic [VERT_W-1:0]  cur_low;
  logic [LINK_W-1:0]  cur_link;
  logic [VERT_W-1:0]  vreg;
  logic [SP_W-1:0]    cnt;
  logic [SP_W-1:0]    sp;
  logic [VERT_W-1:0]  rcc;
  logic [VERT_W-1:0]  swp_addr;
  logic [VERT_W-1:0]  swp_addr_d;
  logic               swp_pend;
  logic [VERT_W-1:0]  tally;

  logic [VERT_W-1:0]  slot_nb;
  logic [LINK_W-1:0]  slot_nx;
  logic               dec_open;
  logic               back_edge;
  logic               pop_cut;

  assign slot_nb   = slot_rd[STACK_W-1:LINK_W];
  assign slot_nx   = slot_rd[LINK_W-1:0];
  assign dec_open  = (cmd.op == OP_DEC) && !vis_rd;
  assign back_edge = (vreg != cur_parent) || (cur_u == r_v);
  assign pop_cut   = (cur_low >= disc_rd);

  // head list memory
  logic              head_we;
  logic [VERT_W-1:0] head_wa;
  logic [LINK_W-1:0] head_wd;
  logic [VERT_W-1:0] head_ra;

  always_comb begin
    head_we = 1'b0;
    head_wa = ea;
    head_wd = '0;
    head_ra = edge_from;
    case (cmd.op)
      OP_EDGE_A: begin
        head_we = !skip;
        head_wa = ea;
        head_wd = su + LINK_W'(1);
        head_ra = eb;
      end
      OP_EDGE_B: begin
        head_we = !skip;
        head_wa = eb;
        head_wd = su + LINK_W'(2);
      end
      OP_ROOT:  head_ra = root_vertex;
      OP_NB:    head_ra = slot_nb;
      OP_SWEEP: begin
        head_we = 1'b1;
        head_wa = swp_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  // adjacency slots, neighbour and next link
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_wa;
  logic [STACK_W-1:0] slot_wd;
  logic [LINK_W-1:0]  link_dec;

  assign link_dec = cur_link - LINK_W'(1);

  always_comb begin
    slot_we = 1'b0;
    slot_wa = su[SLOT_AW-1:0];
    slot_wd = {eb, head_rd};
    case (cmd.op)
      OP_EDGE_A: slot_we = !skip;
      OP_EDGE_B: begin
        slot_we = !skip;
        slot_wa = su[SLOT_AW-1:0] + SLOT_AW'(1);
        // self loop: first half was just linked onto the same list
        slot_wd = {ea, (ea == eb) ? su + LINK_W'(1) : head_rd};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[link_dec[SLOT_AW-1:0]];
  end

  // visited bits
  logic              vis_we;
  logic [VERT_W-1:0] vis_wa;
  logic              vis_wd;

  always_comb begin
    vis_we = 1'b0;
    vis_wa = vreg;
    vis_wd = 1'b1;
    case (cmd.op)
      OP_ROOT: begin
        vis_we = 1'b1;
        vis_wa = root_vertex;
      end
      OP_DEC:  vis_we = !vis_rd;
      OP_SWEEP: begin
        vis_we = 1'b1;
        vis_wa = swp_addr;
        vis_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[slot_nb];
  end

  // discovery order and tree parent, both written on opening a vertex
  logic              open_we;
  logic [VERT_W-1:0] open_wa;
  logic [VERT_W-1:0] disc_wd;
  logic [VERT_W-1:0] parent_wd;
  logic [VERT_W-1:0] disc_ra;

  always_comb begin
    open_we   = dec_open || (cmd.op == OP_ROOT);
    open_wa   = (cmd.op == OP_ROOT) ? root_vertex : vreg;
    disc_wd   = (cmd.op == OP_ROOT) ? '0 : cnt[VERT_W-1:0];
    parent_wd = (cmd.op == OP_ROOT) ? root_vertex : cur_u;
    disc_ra   = (cmd.op == OP_POP_RD) ? cur_parent : slot_nb;
  end

  always_ff @(posedge clk) begin
    if (open_we) begin
      disc_mem[open_wa]   <= disc_wd;
      parent_mem[open_wa] <= parent_wd;
    end
    disc_rd   <= disc_mem[disc_ra];
    parent_rd <= parent_mem[cur_parent];
  end

  // low link written back and walk stack pushed when a child opens
  logic [SP_W-1:0] sp_dec;
  logic [SP_W-1:0] sp_dec2;

  assign sp_dec  = sp - SP_W'(1);
  assign sp_dec2 = sp - SP_W'(2);

  always_ff @(posedge clk) begin
    if (dec_open) begin
      low_mem[cur_u]                 <= cur_low;
      stack_mem[sp_dec[VERT_W-1:0]]  <= {cur_u, cur_link};
    end
    low_rd   <= low_mem[cur_parent];
    stack_rd <= stack_mem[sp_dec2[VERT_W-1:0]];
  end

  // cut marks
  logic              cut_we;
  logic [VERT_W-1:0] cut_wa;
  logic              cut_wd;

  always_comb begin
    cut_we = 1'b0;
    cut_wa = cur_parent;
    cut_wd = 1'b1;
    case (cmd.op)
      OP_POP: cut_we = pop_cut;
      OP_FIN: begin
        cut_we = 1'b1;
        cut_wa = r_v;
        cut_wd = (rcc > VERT_W'(1));
      end
      OP_SWEEP: begin
        cut_we = 1'b1;
        cut_wa = swp_addr;
        cut_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cut_we) cut_mem[cut_wa] <= cut_wd;
    cut_rd <= cut_mem[swp_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      su        <= '0;
      drop      <= 1'b0;
      skip      <= 1'b0;
      sp        <= '0;
      cnt       <= '0;
      swp_addr  <= '0;
      swp_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      swp_pend <= (cmd.op == OP_SWEEP);
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_ACCEPT: begin
          // an edge needs two free slots
          skip <= (su > LINK_W'(SLOT_CAP - 2));
          if (su > LINK_W'(SLOT_CAP - 2)) drop <= 1'b1;
        end
        OP_EDGE_B: if (!skip) su <= su + LINK_W'(2);
        OP_ROOT: begin
          sp  <= SP_W'(1);
          cnt <= SP_W'(1);
        end
        OP_DEC: if (!vis_rd) begin
          sp  <= sp + SP_W'(1);
          cnt <= cnt + SP_W'(1);
        end
        OP_POP:   sp <= sp_dec;
        OP_SWEEP: swp_addr <= swp_addr + VERT_W'(1);
        OP_EMIT: begin
          out_valid <= 1'b1;
          su        <= '0;
          drop      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    swp_addr_d <= swp_addr;
    if (swp_pend && cut_rd && (swp_addr_d != '0) && (swp_addr_d <= vertex_count))
      tally <= tally + VERT_W'(1);
    case (cmd.op)
      OP_ACCEPT: begin
        ea    <= edge_from;
        eb    <= edge_to;
        elast <= last_edge;
      end
      OP_ROOT: begin
        r_v        <= root_vertex;
        cur_u      <= root_vertex;
        cur_parent <= root_vertex;
        cur_low    <= '0;
        rcc        <= '0;
      end
      OP_HEAD: cur_link <= head_rd;
      OP_NB: begin
        vreg     <= slot_nb;
        cur_link <= slot_nx;
      end
      OP_DEC: begin
        if (!vis_rd) begin
          if (cur_u == r_v) rcc <= rcc + VERT_W'(1);
          cur_parent <= cur_u;
          cur_u      <= vreg;
          cur_low    <= cnt[VERT_W-1:0];
          cur_link   <= head_rd;
        end else if (back_edge && (disc_rd < cur_low)) begin
          cur_low <= disc_rd;
        end
      end
      OP_POP: begin
        cur_u      <= stack_rd[STACK_W-1:LINK_W];
        cur_link   <= stack_rd[LINK_W-1:0];
        cur_parent <= parent_rd;
        if (low_rd < cur_low) cur_low <= low_rd;
      end
      OP_FIN: tally <= '0;
      OP_EMIT: begin
        cut_vertex_count <= tally;
        edges_dropped    <= drop;
      end
      default: ;
    endcase
  end

  assign stat.link_zero  = (cur_link == '0);
  assign stat.sp_one     = (sp == SP_W'(1));
  assign stat.last_edge  = elast;
  assign stat.sweep_last = (swp_addr == VERT_W'(VERTS - 1));
  assign stat.out_busy   = out_valid;

  a_slots_even: assert property (@(posedge clk) disable iff (rst) !su[0])
    else $error("slot count went odd");
  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POP) |=> (sp == $past(sp) - SP_W'(1)))
    else $error("stack depth not reduced on pop");
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_EMIT))
    else $error("result raised without emit");

endmodule

>>> rtl/core/apc_ctrl.sv
// sequencer for edge loading, depth-first walk, mark sweep and result hand-off
module apc_ctrl import apc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_TAIL,
    S_WAIT,
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_ROOT,
    S_HEAD,
    S_TEST,
    S_NB,
    S_DEC,
    S_POP,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_next = S_TAIL;
      end
      S_TAIL: state_next = emit ? S_WAIT : S_IDLE;
      S_WAIT: if (!stat.out_busy) begin
        cmd.op     = OP_EMIT;
        state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.op     = OP_ACCEPT;
        state_next = S_EDGE_A;
      end
      S_EDGE_A: begin
        cmd.op     = OP_EDGE_A;
        state_next = S_EDGE_B;
      end
      S_EDGE_B: begin
        cmd.op     = OP_EDGE_B;
        state_next = stat.last_edge ? S_ROOT : S_IDLE;
      end
      S_ROOT: begin
        cmd.op     = OP_ROOT;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.op     = OP_HEAD;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (!stat.link_zero) begin
          cmd.op     = OP_SLOT_RD;
          state_next = S_NB;
        end else if (stat.sp_one) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_POP_RD;
          state_next = S_POP;
        end
      end
      S_NB: begin
        cmd.op     = OP_NB;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.op     = OP_DEC;
        state_next = S_TEST;
      end
      S_POP: begin
        cmd.op     = OP_POP;
        state_next = S_TEST;
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_SWEEP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      emit  <= 1'b0;
    end else begin
      state <= state_next;
      // clearing pass after reset gives no result
      if (state == S_FIN) emit <= 1'b1;
      else if (state == S_TAIL) emit <= emit;
      else if (state == S_IDLE) emit <= 1'b0;
    end
  end

  a_fin_root_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> stat.sp_one)
    else $error("walk finished with vertices on the stack");

endmodule

>>> bench/tb_top.sv
// self-checking bench for the articulation point counter: random graphs, apb setup, stalls
module tb_top import apc_pkg::*; ();

  localparam int MAX_CYCLES  = 4000000;
  localparam int SETTLE      = 1200;
  localparam int EDGE_SLOTS  = 8192;
  localparam int LONG_HOLD   = 4000;

  typedef struct packed {
    logic [VERT_W-1:0] from_v;
    logic [VERT_W-1:0] to_v;
    logic              last;
  } edge_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] cuts;
    logic              dropped;
  } cut_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;

  apc_edge_if   edge_ch ();
  apc_result_if res_ch ();

  articulation_point_counter_top i_dut (
    .clk(clk), .rst(rst), .edge_in(edge_ch.sink), .result_out(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  edge_item_t  edge_q[$];
  cut_result_t cut_q[$];
  edge_item_t  cur_edge;
  bit          edge_taken;
  bit          quiet;
  bit          hold_req;
  int          send_gap, recv_gap, hold_left;
  int          cycles, errors, n_edges, n_graphs, n_results, n_dropped;

  // shadow of the registers and of the graph store
  logic [VERT_W-1:0] cfg_vcount = 1, cfg_root = 1;
  int head_tbl[VERTS];
  int nb_tbl[EDGE_SLOTS];
  int nx_tbl[EDGE_SLOTS];
  int disc_tbl[VERTS], low_tbl[VERTS], par_tbl[VERTS];
  bit seen_tbl[VERTS], cut_tbl[VERTS];
  int stk_v[VERTS], stk_l[VERTS];
  int slots_taken;
  bit drop_flag;

  function automatic void clear_graph();
    for (int i = 0; i < VERTS; i++) begin
      head_tbl[i] = 0;
      seen_tbl[i] = 0;
      disc_tbl[i] = 0;
      cut_tbl[i]  = 0;
    end
    slots_taken = 0;
    drop_flag   = 0;
  endfunction

  function automatic void visit(int v, ref int sp, ref int order);
    seen_tbl[v] = 1;
    disc_tbl[v] = order;
    low_tbl[v]  = order;
    order++;
    if (sp < VERTS) begin
      stk_v[sp] = v;
      stk_l[sp] = head_tbl[v];
      sp++;
    end
  endfunction

  // link the edge, and on the last one run the low-link walk and count cut vertices
  function automatic void predict_cuts(edge_item_t e);
    int a, b, r, sp, order, root_kids, u, lk, s, v, p, top, cnt;
    a = e.from_v;
    b = e.to_v;
    if (slots_taken + 2 > EDGE_SLOTS) begin
      drop_flag = 1;
    end else begin
      nb_tbl[slots_taken] = b;
      nx_tbl[slots_taken] = head_tbl[a];
      head_tbl[a] = slots_taken + 1;
      slots_taken++;
      nb_tbl[slots_taken] = a;
      nx_tbl[slots_taken] = head_tbl[b];
      head_tbl[b] = slots_taken + 1;
      slots_taken++;
    end
    if (!e.last) return;
    r = cfg_root;
    sp = 0;
    order = 0;
    root_kids = 0;
    par_tbl[r] = r;
    visit(r, sp, order);
    while (sp > 0) begin
      u  = stk_v[sp-1];
      lk = stk_l[sp-1];
      if (lk == 0) begin
        sp--;
        if (sp > 0) begin
          p = stk_v[sp-1];
          if (low_tbl[u] >= disc_tbl[p]) cut_tbl[p] = 1;
          if (low_tbl[u] < low_tbl[p]) low_tbl[p] = low_tbl[u];
        end
      end else begin
        s = (lk - 1) % EDGE_SLOTS;
        v = nb_tbl[s] % VERTS;
        stk_l[sp-1] = nx_tbl[s];
        if (!seen_tbl[v]) begin
          par_tbl[v] = u;
          if (u == r) root_kids++;
          visit(v, sp, order);
        end else if (v != par_tbl[u] || u == r) begin
          if (disc_tbl[v] < low_tbl[u]) low_tbl[u] = disc_tbl[v];
        end
      end
    end
    cut_tbl[r] = (root_kids > 1);
    top = (cfg_vcount > VERTS - 1) ? VERTS - 1 : cfg_vcount;
    cnt = 0;
    for (int i = 1; i <= top; i++) if (cut_tbl[i]) cnt++;
    cut_q.insert(cut_q.size(), cut_result_t'{cnt[VERT_W-1:0], drop_flag});
    if (drop_flag) n_dropped++;
    n_graphs++;
    clear_graph();
  endfunction

  // monitor and scoreboard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && edge_ch.valid && edge_ch.ready) begin
      edge_taken = 1;
      n_edges++;
      predict_cuts('{from_v: edge_ch.edge_from, to_v: edge_ch.edge_to,
                     last: edge_ch.last_edge});
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (cut_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        if (res_ch.cut_vertex_count !== cut_q[0].cuts) begin
          $error("cut_vertex_count expected %0d actual %0d",
                 cut_q[0].cuts, res_ch.cut_vertex_count);
          errors++;
        end
        if (res_ch.edges_dropped !== cut_q[0].dropped) begin
          $error("edges_dropped expected %0d actual %0d",
                 cut_q[0].dropped, res_ch.edges_dropped);
          errors++;
        end
        void'(cut_q.pop_front());
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("[articulation_point_counter_top] ERROR");
      $finish;
    end
  end

  // edge driver
  always @(negedge clk) begin
    if (!rst && (!edge_ch.valid || edge_taken)) begin
      edge_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        edge_ch.valid <= 1'b0;
      end else if (edge_q.size() > 0) begin
        cur_edge = edge_q.pop_front();
        edge_ch.valid     <= 1'b1;
        edge_ch.edge_from <= cur_edge.from_v;
        edge_ch.edge_to   <= cur_edge.to_v;
        edge_ch.last_edge <= cur_edge.last;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
      end else begin
        edge_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        hold_req  = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 12);
      end
    end
  end

  task automatic apb_write(int idx, logic [VERT_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_VERTEX_COUNT) cfg_vcount = val;
    else cfg_root = val;
  endtask

  task automatic settle();
    while (edge_q.size() > 0 || edge_ch.valid || cut_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_edge(int a, int b, bit last);
    edge_q.insert(edge_q.size(), edge_item_t'{a[VERT_W-1:0], b[VERT_W-1:0], last});
  endtask

  // random graph over a small window of vertices, sometimes with wild endpoints or a chain from the root
  task automatic queue_graph(int span, int n);
    int a, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else if ($urandom_range(0, 2) == 0 && i > 0) begin
        a = (cfg_root + i - 1) % 1024;
        b = (cfg_root + i) % 1024;
      end else begin
        a = $urandom_range(0, span);
        b = $urandom_range(0, span);
      end
      queue_edge(a, b, i == n - 1);
    end
  endtask

  initial begin
    int vc, rt, items;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    edge_ch.valid = 1'b0; edge_ch.edge_from = '0; edge_ch.edge_to = '0;
    edge_ch.last_edge = 1'b0;
    res_ch.ready = 1'b0;
    cycles = 0; errors = 0; n_edges = 0; n_graphs = 0; n_results = 0; n_dropped = 0;
    send_gap = 0; recv_gap = 0; hold_left = 0; hold_req = 0; quiet = 0; edge_taken = 0;
    clear_graph();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);

    // directed: extremes, self loops, parallel edges, path and star shapes
    apb_write(REG_VERTEX_COUNT, 10'd8);
    apb_write(REG_ROOT_VERTEX, 10'd1);
    queue_edge(1, 2, 0); queue_edge(2, 3, 0); queue_edge(3, 4, 1);   // path
    queue_edge(1, 2, 0); queue_edge(1, 3, 0); queue_edge(1, 4, 1);   // star at root
    queue_edge(1, 2, 0); queue_edge(1, 2, 0); queue_edge(2, 3, 1);   // parallel to parent
    queue_edge(1, 1, 0); queue_edge(2, 2, 0); queue_edge(1, 2, 1);   // self loops
    queue_edge(1, 2, 0); queue_edge(2, 3, 0); queue_edge(3, 1, 1);   // cycle
    queue_edge(5, 6, 1);                                             // root unreached
    queue_edge(1, 0, 0); queue_edge(0, 9, 0); queue_edge(9, 2, 1);   // outside vertex range
    settle();
    apb_write(REG_VERTEX_COUNT, 10'd1023);
    apb_write(REG_ROOT_VERTEX, 10'd1023);
    queue_edge(1023, 0, 0); queue_edge(0, 1023, 0); queue_edge(1023, 682, 0);
    queue_edge(682, 341, 1);
    settle();
    apb_write(REG_VERTEX_COUNT, 10'd0);
    apb_write(REG_ROOT_VERTEX, 10'd0);
    queue_edge(0, 1, 0); queue_edge(0, 2, 1);
    settle();

    // random phases with fresh settings between them
    items = 25;
    for (int ph = 0; items < 1850; ph++) begin
      case (ph % 4)
        0: vc = $urandom_range(1, 24);
        1: vc = 1023;
        2: vc = $urandom_range(1, 1023);
        default: vc = $urandom_range(2, 12);
      endcase
      rt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 6);
      apb_write(REG_VERTEX_COUNT, vc[VERT_W-1:0]);
      apb_write(REG_ROOT_VERTEX, rt[VERT_W-1:0]);
      quiet = (items > 1500);
      if (ph == 2) hold_req = 1;
      for (int g = 0; g < 12; g++) begin
        int n;
        n = $urandom_range(1, 14);
        queue_graph((vc < 30) ? vc + 1 : $urandom_range(8, 30), n);
        items += n;
      end
      settle();
    end

    $display("covered %0d edge transfers in %0d graphs, %0d results, %0d with dropped edges",
             n_edges, n_graphs, n_results, n_dropped);
    if (errors == 0) begin
      $display("[articulation_point_counter_top] OK");
    end else begin
      $display("[articulation_point_counter_top] ERROR");
    end
    $finish;
  end

endmodule
